@@ rtl/mse_pkg.sv @@
package mse_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic                      end_of_set;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_item;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // request accepted on the input channel
        logic pass_init;  // set up pointers for a new merge pass
        logic merge;      // emit one merged element
        logic out_load;   // move the next sorted element to the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sort_done;  // run width already covers the whole set
        logic pass_end;   // current merge step writes the last element of the pass
        logic out_last;   // element being sent out is the final one
        logic out_hold;   // output register full and not taken this cycle
    } status_t;

endpackage

@@ rtl/mse_datapath.sv @@
module mse_datapath
    import mse_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  in_t     s_data,
    input  logic    m_ready,
    output logic    m_valid,
    output out_t    m_data,
    input  cmd_t    cmd,
    output status_t status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;

    // ping-pong stores; pass reads src, writes the other
    logic [VALUE_W-1:0] mem0 [CAPACITY];
    logic [VALUE_W-1:0] mem1 [CAPACITY];

    logic [CW-1:0] count_reg, count_next;
    logic [WW-1:0] width_reg, width_next;
    logic          src_reg, src_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;

    logic [VALUE_W-1:0] rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg;

    logic [SW-1:0] n_ext, w_ext, first_mid, first_hi, run_mid_sum, run_hi_sum;
    logic [SW-1:0] run_mid, run_hi;
    logic [VALUE_W-1:0] rd_a, rd_b, merge_val;
    logic          take_b, run_end, store_ok;
    logic [CW-1:0] a_inc, b_inc, k_inc;

    always_comb begin
        n_ext       = SW'(count_reg);
        w_ext       = SW'(width_reg);
        first_mid   = (w_ext < n_ext) ? w_ext : n_ext;
        first_hi    = ((w_ext << 1) < n_ext) ? (w_ext << 1) : n_ext;
        run_mid_sum = SW'(hi_reg) + w_ext;
        run_hi_sum  = SW'(hi_reg) + (w_ext << 1);
        run_mid     = (run_mid_sum < n_ext) ? run_mid_sum : n_ext;
        run_hi      = (run_hi_sum < n_ext) ? run_hi_sum : n_ext;

        rd_a = src_reg ? rd1a_reg : rd0a_reg;
        rd_b = src_reg ? rd1b_reg : rd0b_reg;

        a_inc = a_reg + CW'(1);
        b_inc = b_reg + CW'(1);
        k_inc = k_reg + CW'(1);

        // ties take the left run, keeping the merge stable
        take_b    = (b_reg < hi_reg)
                    && ((a_reg >= mid_reg) || ($signed(rd_b) < $signed(rd_a)));
        merge_val = take_b ? rd_b : rd_a;
        run_end   = (k_inc == hi_reg);
        store_ok  = (count_reg < CW'(CAPACITY));
    end

    always_comb begin
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        count_next   = count_reg;
        width_next   = width_reg;
        src_next     = src_reg;
        m_valid_next = m_valid_reg;

        if (cmd.load) begin
            if (store_ok) begin
                count_next = count_reg + CW'(1);
            end
            if (s_data.end_of_set) begin
                width_next = WW'(1);
                src_next   = 1'b0;
            end
        end

        if (cmd.pass_init) begin
            a_next   = '0;
            k_next   = '0;
            mid_next = first_mid[CW-1:0];
            b_next   = first_mid[CW-1:0];
            hi_next  = first_hi[CW-1:0];
        end else if (cmd.merge) begin
            k_next = k_inc;
            if (run_end) begin
                a_next   = hi_reg;
                mid_next = run_mid[CW-1:0];
                b_next   = run_mid[CW-1:0];
                hi_next  = run_hi[CW-1:0];
            end else if (take_b) begin
                b_next = b_inc;
            end else begin
                a_next = a_inc;
            end
            if (status.pass_end) begin
                width_next = width_reg << 1;
                src_next   = ~src_reg;
            end
        end else if (cmd.out_load) begin
            a_next = a_inc;
            if (status.out_last) begin
                count_next = '0;
            end
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            width_reg   <= WW'(1);
            src_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            width_reg   <= width_next;
            src_reg     <= src_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        if (cmd.out_load) begin
            m_data_reg.sorted_value <= rd_a;
            m_data_reg.final_item   <= status.out_last;
        end
    end

    // stores: read at the upcoming pointers so data lines up with a_reg/b_reg
    always_ff @(posedge aclk) begin
        if (cmd.load && store_ok) begin
            mem0[count_reg[AW-1:0]] <= s_data.item_value;
        end else if (cmd.merge && src_reg) begin
            mem0[k_reg[AW-1:0]] <= merge_val;
        end
        rd0a_reg <= mem0[a_next[AW-1:0]];
        rd0b_reg <= mem0[b_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.merge && !src_reg) begin
            mem1[k_reg[AW-1:0]] <= merge_val;
        end
        rd1a_reg <= mem1[a_next[AW-1:0]];
        rd1b_reg <= mem1[b_next[AW-1:0]];
    end

    assign status.sort_done = (width_reg >= WW'(count_reg));
    assign status.pass_end  = run_end && (hi_reg == count_reg);
    assign status.out_last  = (a_inc == count_reg);
    assign status.out_hold  = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/mse_ctrl.sv @@
module mse_ctrl
    import mse_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    end_of_set,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_PASS  = 4'b0010,
        S_MERGE = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd.load      = (state_reg == S_LOAD) && s_valid;
        cmd.pass_init = (state_reg == S_PASS);
        cmd.merge     = (state_reg == S_MERGE);
        cmd.out_load  = (state_reg == S_OUT) && !status.out_hold;
        s_ready       = (state_reg == S_LOAD);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (cmd.load && end_of_set) begin
                    state_next = S_PASS;
                end
            end
            S_PASS: begin
                state_next = status.sort_done ? S_OUT : S_MERGE;
            end
            S_MERGE: begin
                if (status.pass_end) begin
                    state_next = S_PASS;
                end
            end
            S_OUT: begin
                if (cmd.out_load && status.out_last) begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/merge_sort_engine_top.sv @@
// Merge sort engine.
// Input channel s_*: one signed 32-bit value per request; end_of_set closes
// the set. Up to CAPACITY values are kept; later ones are dropped, though a
// dropped request carrying end_of_set still closes the set.
// Output channel m_*: the set in ascending order, one value per request,
// final_item high on the last one.
// s_ready stays high throughout loading. After the closing request the set of
// n values is sorted by bottom-up merge passes between two ping-pong stores,
// one element per cycle, in ceil(log2 n) passes. Sorted values then leave
// at one per cycle while m_ready is high. Sorting is bounded by the single
// merge unit and its two read ports.
// Input is not taken while a set is sorted or sent out.
// A stalled m_ready holds the output register and pauses the read-out; the
// next set may start loading once the last value sits in the output register.
// Reset (aresetn low, synchronous) empties the set and clears m_valid.
module merge_sort_engine_top
    import mse_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t    cmd;
    status_t status;

    mse_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .end_of_set (s_data.end_of_set),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    mse_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.pass_init, cmd.merge, cmd.out_load}))
        else $error("more than one datapath command");

    a_merge_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge |-> !status.sort_done)
        else $error("merge step after sort finished");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && status.out_last) |=> s_ready)
        else $error("input not reopened after final value");

    a_out_loads_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("output register not filled");
`endif

endmodule
